/* design/ftlb_pkg.sv */
// Shared types and constants for the FIFO-replacement translation buffer.
`default_nettype none

package ftlb_pkg;

  // Widths fixed by the request and result words.
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned CNT_W  = 32;

  // Default number of translation entries.
  localparam int unsigned ENTRIES_DEF = 16;

  // Request operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // One request word.
  typedef struct packed {
    logic              operation;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
    logic              read_only;
  } req_t;

  // One result word.
  typedef struct packed {
    logic              hit;
    logic [PAGE_W-1:0] found_frame;
    logic              read_only_match;
    logic [CNT_W-1:0]  hits_so_far;
    logic [CNT_W-1:0]  misses_so_far;
    logic [CNT_W-1:0]  fills_so_far;
  } rsp_t;

  // Outcome of the associative compare.
  typedef struct packed {
    logic              hit;
    logic [PAGE_W-1:0] frame;
    logic              read_only;
  } lookup_t;

  // Event counters.
  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] fills;
  } cnt_t;

  // Counter update requests.
  typedef struct packed {
    logic hit_inc;
    logic miss_inc;
    logic fill_inc;
  } cnt_inc_t;

endpackage

`default_nettype wire

/* design/ftlb_entries.sv */
// Entry array: shift-in fill with FIFO eviction and parallel page compare.
`default_nettype none

module ftlb_entries #(
  parameter int unsigned ENTRIES = ftlb_pkg::ENTRIES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fill_en,
  input  wire logic [ftlb_pkg::PAGE_W-1:0] fill_page,
  input  wire logic [ftlb_pkg::PAGE_W-1:0] fill_frame,
  input  wire logic                      fill_read_only,
  input  wire logic [ftlb_pkg::PAGE_W-1:0] lookup_page,
  output ftlb_pkg::lookup_t              lookup
);

  logic [ENTRIES-1:0]               valid_r;
  logic [ftlb_pkg::PAGE_W-1:0]      page_r  [ENTRIES];
  logic [ftlb_pkg::PAGE_W-1:0]      frame_r [ENTRIES];
  logic [ENTRIES-1:0]               ro_r;
  logic [ENTRIES-1:0]               match;

  // Valid bits shift toward slot zero on a fill; the newest entry enters the last slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (fill_en) begin
      for (int i = 0; i < int'(ENTRIES) - 1; i++) begin
        valid_r[i] <= valid_r[i+1];
      end
      valid_r[ENTRIES-1] <= 1'b1;
    end
  end

  // Entry contents follow the same shift; they need no reset since invalid slots never match.
  always_ff @(posedge clk) begin
    if (fill_en) begin
      for (int i = 0; i < int'(ENTRIES) - 1; i++) begin
        page_r[i]  <= page_r[i+1];
        frame_r[i] <= frame_r[i+1];
        ro_r[i]    <= ro_r[i+1];
      end
      page_r[ENTRIES-1]  <= fill_page;
      frame_r[ENTRIES-1] <= fill_frame;
      ro_r[ENTRIES-1]    <= fill_read_only;
    end
  end

  // Compare every slot against the requested page.
  always_comb begin
    for (int i = 0; i < int'(ENTRIES); i++) begin
      match[i] = valid_r[i] && (page_r[i] == lookup_page);
    end
  end

  // The lowest-numbered match supplies the frame; read-only marks of all matches are ORed.
  always_comb begin
    lookup.hit       = |match;
    lookup.read_only = |(match & ro_r);
    lookup.frame     = '0;
    for (int i = int'(ENTRIES) - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup.frame = frame_r[i];
      end
    end
  end

endmodule

`default_nettype wire

/* design/ftlb_counters.sv */
// Wrapping hit, miss and fill counters.
`default_nettype none

module ftlb_counters (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ftlb_pkg::cnt_inc_t inc,
  output ftlb_pkg::cnt_t    cnt,
  output ftlb_pkg::cnt_t    cnt_nxt
);

  ftlb_pkg::cnt_t cnt_r;

  // Values after the current update; each counter wraps naturally at its width.
  always_comb begin
    cnt_nxt = cnt_r;
    if (inc.hit_inc) begin
      cnt_nxt.hits = cnt_r.hits + ftlb_pkg::CNT_W'(1);
    end
    if (inc.miss_inc) begin
      cnt_nxt.misses = cnt_r.misses + ftlb_pkg::CNT_W'(1);
    end
    if (inc.fill_inc) begin
      cnt_nxt.fills = cnt_r.fills + ftlb_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt = cnt_r;

endmodule

`default_nettype wire

/* design/fifo_tlb_lookup_fill.sv */
// Top level of the fully associative translation buffer with FIFO replacement.
`default_nettype none

// Fully associative translation buffer with first-in first-out replacement.
// Each request word is a lookup (compare a page against every valid entry)
// or a fill (evict the oldest entry and insert the new one), and each gives
// exactly one result word carrying the lookup outcome and the hit, miss and
// fill counts after that request. The block takes one word per cycle while
// the receiver takes its results. A request lands in an input register. The
// whole-array compare and the entry shift happen as the request moves on
// to the output register, and the result is written there at the end of
// that cycle, which raises out_valid. The input stalls only while a request
// waits behind a result that the receiver has not taken.
// The combinational compare across all ENTRIES slots sets the critical path.
// Valid bits clear at reset; no clearing pass is needed.
module fifo_tlb_lookup_fill #(
  parameter int unsigned ENTRIES = ftlb_pkg::ENTRIES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire ftlb_pkg::req_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output ftlb_pkg::rsp_t out_data
);

  logic               req_valid_r;
  ftlb_pkg::req_t     req_r;
  logic               rsp_valid_r;
  ftlb_pkg::rsp_t     rsp_r;
  logic               advance;
  logic               is_fill;
  ftlb_pkg::lookup_t  lookup;
  ftlb_pkg::cnt_inc_t inc;
  ftlb_pkg::cnt_t     cnt;
  ftlb_pkg::cnt_t     cnt_nxt;

  // The request moves on when the result register is free or being drained.
  assign advance  = req_valid_r && (!rsp_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;
  assign is_fill  = (req_r.operation == ftlb_pkg::OP_FILL);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  ftlb_entries #(
    .ENTRIES(ENTRIES)
  ) u_entries (
    .clk           (clk),
    .rst_n         (rst_n),
    .fill_en       (advance && is_fill),
    .fill_page     (req_r.page),
    .fill_frame    (req_r.frame),
    .fill_read_only(req_r.read_only),
    .lookup_page   (req_r.page),
    .lookup        (lookup)
  );

  // Count the outcome of the request that is moving to the result register.
  always_comb begin
    inc.fill_inc = advance && is_fill;
    inc.hit_inc  = advance && !is_fill && lookup.hit;
    inc.miss_inc = advance && !is_fill && !lookup.hit;
  end

  ftlb_counters u_counters (
    .clk    (clk),
    .rst_n  (rst_n),
    .inc    (inc),
    .cnt    (cnt),
    .cnt_nxt(cnt_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (advance) begin
      rsp_valid_r <= 1'b1;
    end else if (out_ready) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r.hit             <= !is_fill && lookup.hit;
      rsp_r.found_frame     <= is_fill ? '0 : lookup.frame;
      rsp_r.read_only_match <= !is_fill && lookup.read_only;
      rsp_r.hits_so_far     <= cnt_nxt.hits;
      rsp_r.misses_so_far   <= cnt_nxt.misses;
      rsp_r.fills_so_far    <= cnt_nxt.fills;
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_data  = rsp_r;

  // A miss or a fill never reports a frame or a read-only mark.
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.found_frame == '0 && !out_data.read_only_match))
    else $error("miss or fill result carries a frame or read-only mark");

  // A fill advances the fill count by exactly one in its result.
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_fill) |=> (out_data.fills_so_far == $past(cnt.fills) + 32'd1))
    else $error("fill count in result is wrong");

  // A lookup changes exactly one of the hit and miss counts.
  a_lookup_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !is_fill) |=>
      ((cnt.hits != $past(cnt.hits)) != (cnt.misses != $past(cnt.misses))))
    else $error("lookup did not update exactly one of hit and miss counts");

  // Input stalls only while a request waits behind an unconsumed result.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (req_valid_r && rsp_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

/* test/fifo_tlb_lookup_fill_tb.sv */
// Self-checking testbench for the FIFO-replacement translation buffer.
`timescale 1ns / 1ps

module fifo_tlb_lookup_fill_tb;

  localparam int N_ENTRIES = int'(ftlb_pkg::ENTRIES_DEF);
  localparam int unsigned PAGE_W = ftlb_pkg::PAGE_W;
  localparam int unsigned CNT_W = ftlb_pkg::CNT_W;
  localparam int RANDOM_ITEMS = 1350;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ftlb_pkg::req_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  ftlb_pkg::rsp_t out_data;

  fifo_tlb_lookup_fill #(
    .ENTRIES(N_ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the translation entries and counters.
  logic             shadow_valid [N_ENTRIES];
  logic [PAGE_W-1:0] shadow_page [N_ENTRIES];
  logic [PAGE_W-1:0] shadow_frame [N_ENTRIES];
  logic             shadow_ro [N_ENTRIES];
  ftlb_pkg::cnt_t   shadow_cnt;

  // Result words still owed by the block, oldest first.
  ftlb_pkg::rsp_t pending_rsp_q[$];

  // Directed stimulus table.
  ftlb_pkg::req_t dir_req_q[$];
  bit   dir_typed_q[$];
  ftlb_pkg::rsp_t dir_want_q[$];

  int mismatches = 0;
  int checked = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  // Receiver stall pattern state.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_period = 4;
  int rx_tick = 0;

  function automatic ftlb_pkg::req_t mk_req(logic op, logic [PAGE_W-1:0] pg,
                                            logic [PAGE_W-1:0] fr, logic ro);
    ftlb_pkg::req_t r;
    r.operation = op;
    r.page = pg;
    r.frame = fr;
    r.read_only = ro;
    return r;
  endfunction

  function automatic ftlb_pkg::rsp_t mk_rsp(logic h, logic [PAGE_W-1:0] ff, logic rom,
                                            logic [CNT_W-1:0] nh, logic [CNT_W-1:0] nm,
                                            logic [CNT_W-1:0] nf);
    ftlb_pkg::rsp_t r;
    r.hit = h;
    r.found_frame = ff;
    r.read_only_match = rom;
    r.hits_so_far = nh;
    r.misses_so_far = nm;
    r.fills_so_far = nf;
    return r;
  endfunction

  // Apply one request to the shadow buffer and produce the result word it owes.
  task automatic translate(input ftlb_pkg::req_t r, output ftlb_pkg::rsp_t e);
    int i;
    bit found;
    e = '0;
    found = 1'b0;
    if (r.operation == ftlb_pkg::OP_FILL) begin
      // Oldest entry sits in slot 0 and drops out; the new one enters last.
      for (i = 0; i < N_ENTRIES - 1; i++) begin
        shadow_valid[i] = shadow_valid[i+1];
        shadow_page[i]  = shadow_page[i+1];
        shadow_frame[i] = shadow_frame[i+1];
        shadow_ro[i]    = shadow_ro[i+1];
      end
      shadow_valid[N_ENTRIES-1] = 1'b1;
      shadow_page[N_ENTRIES-1]  = r.page;
      shadow_frame[N_ENTRIES-1] = r.frame;
      shadow_ro[N_ENTRIES-1]    = r.read_only;
      shadow_cnt.fills = shadow_cnt.fills + 32'd1;
    end else begin
      // Lowest valid match gives the frame; read-only ORs over all matches.
      for (i = 0; i < N_ENTRIES; i++) begin
        if (shadow_valid[i] && shadow_page[i] == r.page) begin
          if (!found) begin
            found = 1'b1;
            e.found_frame = shadow_frame[i];
          end
          if (shadow_ro[i]) e.read_only_match = 1'b1;
        end
      end
      e.hit = found;
      if (found) shadow_cnt.hits = shadow_cnt.hits + 32'd1;
      else shadow_cnt.misses = shadow_cnt.misses + 32'd1;
    end
    e.hits_so_far = shadow_cnt.hits;
    e.misses_so_far = shadow_cnt.misses;
    e.fills_so_far = shadow_cnt.fills;
  endtask

  task automatic add_row(input ftlb_pkg::req_t r, input bit typed,
                         input ftlb_pkg::rsp_t want);
    dir_req_q.push_back(r);
    dir_typed_q.push_back(typed);
    dir_want_q.push_back(want);
  endtask

  // Offer one request word, wait for acceptance, then idle between bursts.
  task automatic send_word(input ftlb_pkg::req_t w, input bit typed,
                           input ftlb_pkg::rsp_t want);
    ftlb_pkg::rsp_t e;
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    translate(w, e);
    pending_rsp_q.push_back(typed ? want : e);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data <= mk_req(1'($urandom_range(0, 1)), PAGE_W'($urandom), PAGE_W'($urandom),
                          1'($urandom_range(0, 1)));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: switches among always ready, coin-flip, and periodic stall patterns.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(32, 200);
      rx_period <= $urandom_range(2, 8);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_tick % rx_period) != 0;
      default: out_ready <= (rx_tick % rx_period) == 0;
    endcase
  end

  // Result checker and stall watchdog.
  always @(posedge clk) begin
    ftlb_pkg::rsp_t want;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_ready) begin
        checked++;
        if (pending_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing expected: %p", $realtime, out_data);
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_data.hit !== want.hit ||
              out_data.found_frame !== want.found_frame ||
              out_data.read_only_match !== want.read_only_match ||
              out_data.hits_so_far !== want.hits_so_far ||
              out_data.misses_so_far !== want.misses_so_far ||
              out_data.fills_so_far !== want.fills_so_far) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch hit %0b/%0b frame %h/%h ro %0b/%0b cnt %0d,%0d,%0d/%0d,%0d,%0d",
                       $realtime, want.hit, out_data.hit, want.found_frame,
                       out_data.found_frame, want.read_only_match,
                       out_data.read_only_match, want.hits_so_far,
                       want.misses_so_far, want.fills_so_far, out_data.hits_so_far,
                       out_data.misses_so_far, out_data.fills_so_far);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("fifo_tlb_lookup_fill_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [PAGE_W-1:0] pool [32];
    logic [PAGE_W-1:0] pg;
    logic op;
    int pool_size;
    int fill_pct;
    int seg_len;
    int rand_sent;
    int k;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    for (k = 0; k < N_ENTRIES; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_page[k] = '0;
      shadow_frame[k] = '0;
      shadow_ro[k] = 1'b0;
    end
    shadow_cnt = '0;

    // Directed rows: extremes, invalid slots holding page zero, duplicates.
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, '0, PAGE_MAX, 1'b1), 1'b1,
            mk_rsp(1'b0, '0, 1'b0, 32'd0, 32'd1, 32'd0));
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, PAGE_MAX, '0, 1'b0), 1'b1,
            mk_rsp(1'b0, '0, 1'b0, 32'd0, 32'd2, 32'd0));
    add_row(mk_req(ftlb_pkg::OP_FILL, '0, PAGE_MAX, 1'b1), 1'b1,
            mk_rsp(1'b0, '0, 1'b0, 32'd0, 32'd2, 32'd1));
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, '0, '0, 1'b0), 1'b1,
            mk_rsp(1'b1, PAGE_MAX, 1'b1, 32'd1, 32'd2, 32'd1));
    add_row(mk_req(ftlb_pkg::OP_FILL, PAGE_MAX, '0, 1'b0), 1'b1,
            mk_rsp(1'b0, '0, 1'b0, 32'd1, 32'd2, 32'd2));
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, PAGE_MAX, PAGE_MAX, 1'b1), 1'b1,
            mk_rsp(1'b1, '0, 1'b0, 32'd2, 32'd2, 32'd2));
    add_row(mk_req(ftlb_pkg::OP_FILL, '0, 20'h00001, 1'b0), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, '0, '0, 1'b0), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, 20'h00001, 20'h00001, 1'b0), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_FILL, 20'hAAAAA, 20'h55555, 1'b1), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, 20'hAAAAA, '0, 1'b0), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, 20'h55555, '0, 1'b0), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_FILL, 20'h55555, 20'hAAAAA, 1'b0), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, 20'h55555, '0, 1'b1), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_FILL, '0, 20'h00002, 1'b0), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, '0, PAGE_MAX, 1'b1), 1'b0, '0);
    add_row(mk_req(ftlb_pkg::OP_LOOKUP, PAGE_MAX, '0, 1'b0), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    for (k = 0; k < dir_req_q.size(); k++)
      send_word(dir_req_q[k], dir_typed_q[k], dir_want_q[k]);

    // Random segments: each draws pages from its own small pool so that hits,
    // duplicate entries and evictions are frequent, with some stray pages mixed in.
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      pool_size = $urandom_range(2, 32);
      for (k = 0; k < pool_size; k++) begin
        case ($urandom_range(0, 7))
          0: pool[k] = '0;
          1: pool[k] = PAGE_MAX;
          default: pool[k] = PAGE_W'($urandom);
        endcase
      end
      fill_pct = $urandom_range(15, 65);
      seg_len = $urandom_range(80, 240);
      for (k = 0; k < seg_len && rand_sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0) pg = PAGE_W'($urandom);
        else pg = pool[$urandom_range(0, pool_size - 1)];
        op = ($urandom_range(0, 99) < fill_pct) ? ftlb_pkg::OP_FILL : ftlb_pkg::OP_LOOKUP;
        send_word(mk_req(op, pg, PAGE_W'($urandom), 1'($urandom_range(0, 1))), 1'b0, '0);
        rand_sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then give any stray word time to show up.
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_rsp_q.size() != 0) mismatches += pending_rsp_q.size();

    $display("Sent %0d requests: %0d fills, %0d lookup hits, %0d lookup misses.",
             dir_req_q.size() + rand_sent, shadow_cnt.fills, shadow_cnt.hits,
             shadow_cnt.misses);
    $display("Checked %0d result words under bursty input and patterned output stalls.",
             checked);
    if (mismatches == 0) begin
      $display("fifo_tlb_lookup_fill_tb: done, clean");
    end else begin
      $display("fifo_tlb_lookup_fill_tb: done, errors");
    end
    $finish;
  end

endmodule
